// ===== src/jsu_pkg.sv =====
// shared types and constants of the json string unescape unit
`timescale 1ns / 1ps

package jsu_pkg;

  // depth of the job queue between front and back
  localparam int unsigned FifoDepth = 4;

  // width of a unicode code point
  localparam int unsigned CpW = 21;

  // utf-8 length thresholds and lead/continuation markers
  localparam logic [CpW-1:0] CpMax1 = 21'h00007F;
  localparam logic [CpW-1:0] CpMax2 = 21'h0007FF;
  localparam logic [CpW-1:0] CpMax3 = 21'h00FFFF;
  localparam logic [CpW-1:0] CpSuppBase = 21'h010000;
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;

  // what the back end has to do with a queued job
  typedef enum logic [1:0] {
    JobRaw = 2'd0,
    JobCp  = 2'd1,
    JobEnd = 2'd2,
    JobErr = 2'd3
  } job_kind_e;

  // result word kind
  typedef enum logic [1:0] {
    KindData = 2'd0,
    KindEnd  = 2'd1,
    KindErr  = 2'd2
  } out_kind_e;

  // error codes
  typedef enum logic [3:0] {
    ErrNone         = 4'd0,
    ErrNoOpenQuote  = 4'd1,
    ErrControlByte  = 4'd2,
    ErrBadEscape    = 4'd3,
    ErrBadHex       = 4'd4,
    ErrHighNoLow    = 4'd5,
    ErrBadLow       = 4'd6,
    ErrUnpairedLow  = 4'd7,
    ErrTruncEscape  = 4'd8,
    ErrTruncUnicode = 4'd9,
    ErrUnterminated = 4'd10
  } err_code_e;

  // one classified job
  typedef struct packed {
    job_kind_e       kind;
    err_code_e       err;
    logic [CpW-1:0]  cp;
  } job_t;

endpackage

// ===== src/json_string_unescape_utf8_unit.sv =====
// top level: json string unescape to utf-8, front end, job queue and back end
// with the queue empty and the output register free, the first result word of a byte
//   is registered in the job queue and then in the output register
// throughput: one input byte per cycle; one result word per cycle while out_ready_i
//   does not stall, so a \u escape gives one word per utf-8 byte (1 to 4 bytes)
// the input side stalls only when the job queue (FifoDepth entries) is full
// reset: asynchronous, active low; returns to idle awaiting the opening quote and
//   empties the queue and output register; no clearing pass
`timescale 1ns / 1ps

module json_string_unescape_utf8_unit #(
  parameter int unsigned FifoDepth = jsu_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input word channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  // result word channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [3:0] err_code_o,
  output logic       last_o
);

  // front to queue
  logic          push_valid;
  logic          push_ready;
  jsu_pkg::job_t push_job;

  // queue to back
  logic          pop_valid;
  logic          pop_ready;
  jsu_pkg::job_t pop_job;

  // front end: tracks the string/escape/hex state one byte at a time and turns
  // each byte into at most one job (raw byte, code point, end marker or error)
  jsu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .job_valid_o    (push_valid),
    .job_ready_i    (push_ready),
    .job_o          (push_job)
  );

  // short queue so the front keeps taking bytes while a multi-byte code point
  // is still being sent out
  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  // back end: utf-8 encode and, while out_ready_i does not stall it, send one result
  // word per cycle through an output register, marking the final word of each job
  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (pop_valid),
    .job_ready_o  (pop_ready),
    .job_i        (pop_job),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .err_code_o   (err_code_o),
    .last_o       (last_o)
  );

endmodule

// ===== src/jsu_fifo.sv =====
// short job queue between the front and back ends
`timescale 1ns / 1ps

module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  jsu_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output jsu_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/jsu_front.sv =====
// front end: string state machine that classifies each input byte into a job
`timescale 1ns / 1ps

module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_input_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output jsu_pkg::job_t job_o
);

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChU = 8'h75;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [15:0] HighLo = 16'hD800;
  localparam logic [15:0] HighHi = 16'hDBFF;
  localparam logic [15:0] LowLo = 16'hDC00;
  localparam logic [15:0] LowHi = 16'hDFFF;

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeStr   = 3'd1,
    ModeEsc   = 3'd2,
    ModeHexHi = 3'd3,
    ModeLowBs = 3'd4,
    ModeLowU  = 3'd5,
    ModeHexLo = 3'd6
  } mode_e;

  mode_e mode_q, mode_d;
  logic [11:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hs_q, hs_d;

  logic accept;
  logic has_job;
  logic fail;
  logic go_idle;
  jsu_pkg::err_code_e fail_code;
  jsu_pkg::job_t job;
  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] hex_word;
  logic        is_high, is_low;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = in_valid_i && has_job;
  assign job_o       = job;

  // hex digit decode
  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      digit = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      digit = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      digit = 4'(in_byte_i - 8'h37);
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign hex_word = {acc_q, digit};
  assign is_high  = (hex_word >= HighLo) && (hex_word <= HighHi);
  assign is_low   = (hex_word >= LowLo) && (hex_word <= LowHi);

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    hs_d      = hs_q;
    has_job   = 1'b0;
    fail      = 1'b0;
    go_idle   = 1'b0;
    fail_code = jsu_pkg::ErrNone;
    job.kind  = jsu_pkg::JobRaw;
    job.err   = jsu_pkg::ErrNone;
    job.cp    = jsu_pkg::CpW'(in_byte_i);
    unique case (mode_q)
      ModeStr: begin
        if (end_of_input_i) begin
          fail      = 1'b1;
          fail_code = jsu_pkg::ErrUnterminated;
        end else if (in_byte_i == ChQuote) begin
          go_idle  = 1'b1;
          has_job  = 1'b1;
          job.kind = jsu_pkg::JobEnd;
        end else if (in_byte_i < ChSpace) begin
          fail      = 1'b1;
          fail_code = jsu_pkg::ErrControlByte;
        end else if (in_byte_i == ChBslash) begin
          mode_d = ModeEsc;
        end else begin
          has_job = 1'b1;
        end
      end
      ModeEsc: begin
        if (end_of_input_i) begin
          fail      = 1'b1;
          fail_code = jsu_pkg::ErrTruncEscape;
        end else begin
          mode_d  = ModeStr;
          has_job = 1'b1;
          unique case (in_byte_i)
            ChQuote, ChBslash, ChSlash: job.cp = jsu_pkg::CpW'(in_byte_i);
            ChB: job.cp = jsu_pkg::CpW'(8'h08);
            ChF: job.cp = jsu_pkg::CpW'(8'h0C);
            ChN: job.cp = jsu_pkg::CpW'(8'h0A);
            ChR: job.cp = jsu_pkg::CpW'(8'h0D);
            ChT: job.cp = jsu_pkg::CpW'(8'h09);
            ChU: begin
              has_job = 1'b0;
              mode_d  = ModeHexHi;
              acc_d   = '0;
              cnt_d   = '0;
            end
            default: begin
              fail      = 1'b1;
              fail_code = jsu_pkg::ErrBadEscape;
            end
          endcase
        end
      end
      ModeHexHi, ModeHexLo: begin
        if (end_of_input_i) begin
          fail      = 1'b1;
          fail_code = jsu_pkg::ErrTruncUnicode;
        end else if (!digit_ok) begin
          fail      = 1'b1;
          fail_code = jsu_pkg::ErrBadHex;
        end else if (cnt_q != 2'd3) begin
          acc_d = hex_word[11:0];
          cnt_d = cnt_q + 1'b1;
        end else begin
          acc_d = '0;
          cnt_d = '0;
          if (mode_q == ModeHexHi) begin
            if (is_high) begin
              hs_d   = hex_word[9:0];
              mode_d = ModeLowBs;
            end else if (is_low) begin
              fail      = 1'b1;
              fail_code = jsu_pkg::ErrUnpairedLow;
            end else begin
              mode_d   = ModeStr;
              has_job  = 1'b1;
              job.kind = jsu_pkg::JobCp;
              job.cp   = jsu_pkg::CpW'(hex_word);
            end
          end else begin
            if (!is_low) begin
              fail      = 1'b1;
              fail_code = jsu_pkg::ErrBadLow;
            end else begin
              // supplementary plane: base plus ten high and ten low bits
              mode_d   = ModeStr;
              hs_d     = '0;
              has_job  = 1'b1;
              job.kind = jsu_pkg::JobCp;
              job.cp   = jsu_pkg::CpSuppBase + jsu_pkg::CpW'({hs_q, hex_word[9:0]});
            end
          end
        end
      end
      ModeLowBs: begin
        if (end_of_input_i || in_byte_i != ChBslash) begin
          fail      = 1'b1;
          fail_code = jsu_pkg::ErrHighNoLow;
        end else begin
          mode_d = ModeLowU;
        end
      end
      ModeLowU: begin
        if (end_of_input_i || in_byte_i != ChU) begin
          fail      = 1'b1;
          fail_code = jsu_pkg::ErrHighNoLow;
        end else begin
          mode_d = ModeHexLo;
          acc_d  = '0;
          cnt_d  = '0;
        end
      end
      default: begin
        go_idle = 1'b1;
        if (!end_of_input_i && in_byte_i == ChQuote) begin
          go_idle = 1'b0;
          mode_d  = ModeStr;
          acc_d   = '0;
          cnt_d   = '0;
          hs_d    = '0;
        end else begin
          fail      = 1'b1;
          fail_code = jsu_pkg::ErrNoOpenQuote;
        end
      end
    endcase
    if (fail) begin
      go_idle  = 1'b1;
      has_job  = 1'b1;
      job.kind = jsu_pkg::JobErr;
      job.err  = fail_code;
      job.cp   = '0;
    end
    if (go_idle) begin
      mode_d = ModeIdle;
      acc_d  = '0;
      cnt_d  = '0;
      hs_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      acc_q  <= '0;
      cnt_q  <= '0;
      hs_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      hs_q   <= hs_d;
    end
  end

endmodule

// ===== src/jsu_back.sv =====
// back end: utf-8 encoder and result serialiser with output register
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  jsu_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic [1:0]    kind_o,
  output logic [3:0]    err_code_o,
  output logic          last_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic [1:0] kind_q, kind_d;
  logic [3:0] err_q, err_d;
  logic       last_q, last_d;

  logic       load;
  logic       is_last;
  logic [1:0] n_m1;
  logic [7:0] enc [4];
  logic [jsu_pkg::CpW-1:0] cp;

  assign cp = job_i.cp;

  // utf-8 length and byte layout
  always_comb begin
    n_m1 = 2'd0;
    enc[0] = cp[7:0];
    enc[1] = 8'h00;
    enc[2] = 8'h00;
    enc[3] = 8'h00;
    if (job_i.kind == jsu_pkg::JobCp) begin
      if (cp <= jsu_pkg::CpMax1) begin
        enc[0] = {1'b0, cp[6:0]};
      end else if (cp <= jsu_pkg::CpMax2) begin
        n_m1   = 2'd1;
        enc[0] = jsu_pkg::Lead2 | {3'b000, cp[10:6]};
        enc[1] = jsu_pkg::ContMark | {2'b00, cp[5:0]};
      end else if (cp <= jsu_pkg::CpMax3) begin
        n_m1   = 2'd2;
        enc[0] = jsu_pkg::Lead3 | {4'h0, cp[15:12]};
        enc[1] = jsu_pkg::ContMark | {2'b00, cp[11:6]};
        enc[2] = jsu_pkg::ContMark | {2'b00, cp[5:0]};
      end else begin
        n_m1   = 2'd3;
        enc[0] = jsu_pkg::Lead4 | {5'b00000, cp[20:18]};
        enc[1] = jsu_pkg::ContMark | {2'b00, cp[17:12]};
        enc[2] = jsu_pkg::ContMark | {2'b00, cp[11:6]};
        enc[3] = jsu_pkg::ContMark | {2'b00, cp[5:0]};
      end
    end
  end

  assign load        = job_valid_i && (!out_valid_q || out_ready_i);
  assign is_last     = (idx_q == n_m1);
  assign job_ready_o = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    kind_d      = kind_q;
    err_d       = err_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = 1'b1;
      last_d      = is_last;
      idx_d       = is_last ? 2'd0 : idx_q + 1'b1;
      unique case (job_i.kind)
        jsu_pkg::JobRaw, jsu_pkg::JobCp: begin
          byte_d = enc[idx_q];
          kind_d = jsu_pkg::KindData;
          err_d  = jsu_pkg::ErrNone;
        end
        jsu_pkg::JobEnd: begin
          byte_d = 8'h00;
          kind_d = jsu_pkg::KindEnd;
          err_d  = jsu_pkg::ErrNone;
        end
        default: begin
          byte_d = 8'h00;
          kind_d = jsu_pkg::KindErr;
          err_d  = job_i.err;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
    err_q  <= err_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign kind_o      = kind_q;
  assign err_code_o  = err_q;
  assign last_o      = last_q;

endmodule
